// ----- rtl/bsg_pkg.sv -----
// Shared types, codes and the per-song formula microcode for the sample generator.
package bsg_pkg;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHR, OP_DIV, OP_MOD, OP_DIV5, OP_END
  } op_t;

  typedef enum logic [1:0] {
    ENG_IDLE, ENG_FETCH, ENG_EXEC, ENG_WAIT
  } eng_state_t;

  // operand sources
  localparam logic [2:0] SRC_T   = 3'd0;
  localparam logic [2:0] SRC_A   = 3'd1;
  localparam logic [2:0] SRC_B   = 3'd2;
  localparam logic [2:0] SRC_IMM = 3'd3;
  localparam logic [2:0] SRC_R3  = 3'd4;
  localparam logic [2:0] SRC_R4  = 3'd5;
  localparam logic [2:0] SRC_R5  = 3'd6;

  // scratch destinations
  localparam logic [1:0] D_R3 = 2'd0;
  localparam logic [1:0] D_R4 = 2'd1;
  localparam logic [1:0] D_R5 = 2'd2;

  localparam logic [3:0] SONG_LAST = 4'd9;

  localparam logic [1:0] REG_GAP_MIN = 2'd0;
  localparam logic [1:0] REG_GAP_MAX = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_HOLD    = 2'd3;

  typedef struct packed {
    op_t         op;
    logic [1:0]  dst;
    logic [2:0]  sa;
    logic [2:0]  sb;
    logic [31:0] imm;
  } instr_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  function automatic instr_t ins(input op_t op, input logic [1:0] dst,
                                 input logic [2:0] sa, input logic [2:0] sb,
                                 input logic [31:0] imm);
    instr_t i;
    i.op  = op;
    i.dst = dst;
    i.sa  = sa;
    i.sb  = sb;
    i.imm = imm;
    return i;
  endfunction

  function automatic instr_t prog(input logic [3:0] song, input logic [4:0] pc);
    instr_t p;
    p = ins(OP_END, D_R3, SRC_T, SRC_T, 32'd0);
    case (song)
      4'd0: begin
        case (pc)
          5'd0:  p = ins(OP_DIV5, D_R3, SRC_A,   SRC_IMM, 32'd5);
          5'd1:  p = ins(OP_ADD, D_R3, SRC_R3,  SRC_IMM, 32'd5);
          5'd2:  p = ins(OP_MUL, D_R3, SRC_T,   SRC_R3,  32'd0);
          5'd3:  p = ins(OP_SHR, D_R4, SRC_T,   SRC_IMM, 32'd7);
          5'd4:  p = ins(OP_AND, D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd5:  p = ins(OP_DIV5, D_R4, SRC_B,   SRC_IMM, 32'd5);
          5'd6:  p = ins(OP_SUB, D_R4, SRC_IMM, SRC_R4,  32'd10);
          5'd7:  p = ins(OP_SHR, D_R4, SRC_T,   SRC_R4,  32'd0);
          5'd8:  p = ins(OP_MUL, D_R5, SRC_T,   SRC_IMM, 32'd3);
          5'd9:  p = ins(OP_AND, D_R4, SRC_R4,  SRC_R5,  32'd0);
          5'd10: p = ins(OP_OR,  D_R3, SRC_R3,  SRC_R4,  32'd0);
          default: ;
        endcase
      end
      4'd1: begin
        case (pc)
          5'd0:  p = ins(OP_SHR, D_R3, SRC_A,  SRC_IMM, 32'd1);
          5'd1:  p = ins(OP_ADD, D_R3, SRC_R3, SRC_IMM, 32'd9);
          5'd2:  p = ins(OP_SHR, D_R3, SRC_T,  SRC_R3,  32'd0);
          5'd3:  p = ins(OP_OR,  D_R3, SRC_R3, SRC_T,   32'd0);
          5'd4:  p = ins(OP_SHR, D_R4, SRC_T,  SRC_IMM, 32'd7);
          5'd5:  p = ins(OP_OR,  D_R3, SRC_R3, SRC_R4,  32'd0);
          5'd6:  p = ins(OP_MUL, D_R3, SRC_R3, SRC_T,   32'd0);
          5'd7:  p = ins(OP_SHR, D_R4, SRC_B,  SRC_IMM, 32'd1);
          5'd8:  p = ins(OP_ADD, D_R4, SRC_R4, SRC_IMM, 32'd11);
          5'd9:  p = ins(OP_SHR, D_R4, SRC_T,  SRC_R4,  32'd0);
          5'd10: p = ins(OP_SHR, D_R5, SRC_T,  SRC_IMM, 32'd9);
          5'd11: p = ins(OP_OR,  D_R4, SRC_R4, SRC_R5,  32'd0);
          5'd12: p = ins(OP_AND, D_R3, SRC_R3, SRC_R4,  32'd0);
          default: ;
        endcase
      end
      4'd2: begin
        case (pc)
          5'd0:  p = ins(OP_MUL, D_R3, SRC_T,   SRC_IMM, 32'd9);
          5'd1:  p = ins(OP_SHR, D_R4, SRC_T,   SRC_IMM, 32'd4);
          5'd2:  p = ins(OP_AND, D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd3:  p = ins(OP_SHR, D_R4, SRC_A,   SRC_IMM, 32'd1);
          5'd4:  p = ins(OP_ADD, D_R4, SRC_R4,  SRC_IMM, 32'd7);
          5'd5:  p = ins(OP_SHR, D_R4, SRC_T,   SRC_R4,  32'd0);
          5'd6:  p = ins(OP_MUL, D_R5, SRC_T,   SRC_IMM, 32'd5);
          5'd7:  p = ins(OP_AND, D_R4, SRC_R4,  SRC_R5,  32'd0);
          5'd8:  p = ins(OP_OR,  D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd9:  p = ins(OP_SHR, D_R4, SRC_B,   SRC_IMM, 32'd1);
          5'd10: p = ins(OP_SUB, D_R4, SRC_IMM, SRC_R4,  32'd1024);
          5'd11: p = ins(OP_DIV, D_R4, SRC_T,   SRC_R4,  32'd0);
          5'd12: p = ins(OP_MUL, D_R5, SRC_T,   SRC_IMM, 32'd3);
          5'd13: p = ins(OP_AND, D_R4, SRC_R4,  SRC_R5,  32'd0);
          5'd14: p = ins(OP_OR,  D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd15: p = ins(OP_SUB, D_R3, SRC_R3,  SRC_IMM, 32'd1);
          default: ;
        endcase
      end
      4'd3: begin
        case (pc)
          5'd0:  p = ins(OP_SHR, D_R3, SRC_A,   SRC_IMM, 32'd1);
          5'd1:  p = ins(OP_SUB, D_R3, SRC_IMM, SRC_R3,  32'd16);
          5'd2:  p = ins(OP_SHR, D_R3, SRC_T,   SRC_R3,  32'd0);
          5'd3:  p = ins(OP_SHR, D_R3, SRC_T,   SRC_R3,  32'd0);
          5'd4:  p = ins(OP_OR,  D_R3, SRC_R3,  SRC_T,   32'd0);
          5'd5:  p = ins(OP_SHR, D_R4, SRC_T,   SRC_IMM, 32'd6);
          5'd6:  p = ins(OP_OR,  D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd7:  p = ins(OP_MUL, D_R3, SRC_R3,  SRC_IMM, 32'd10);
          5'd8:  p = ins(OP_SHR, D_R4, SRC_B,   SRC_IMM, 32'd1);
          5'd9:  p = ins(OP_ADD, D_R4, SRC_R4,  SRC_IMM, 32'd7);
          5'd10: p = ins(OP_SHR, D_R5, SRC_T,   SRC_IMM, 32'd11);
          5'd11: p = ins(OP_AND, D_R4, SRC_R4,  SRC_R5,  32'd0);
          5'd12: p = ins(OP_ADD, D_R3, SRC_R3,  SRC_R4,  32'd0);
          default: ;
        endcase
      end
      4'd4: begin
        case (pc)
          5'd0:  p = ins(OP_SHR, D_R3, SRC_B,   SRC_IMM, 32'd1);
          5'd1:  p = ins(OP_SUB, D_R3, SRC_IMM, SRC_R3,  32'd11);
          5'd2:  p = ins(OP_SHR, D_R3, SRC_T,   SRC_R3,  32'd0);
          5'd3:  p = ins(OP_SHR, D_R4, SRC_T,   SRC_IMM, 32'd8);
          5'd4:  p = ins(OP_AND, D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd5:  p = ins(OP_SUB, D_R4, SRC_IMM, SRC_A,   32'd123);
          5'd6:  p = ins(OP_AND, D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd7:  p = ins(OP_SHR, D_R4, SRC_T,   SRC_IMM, 32'd3);
          5'd8:  p = ins(OP_AND, D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd9:  p = ins(OP_MUL, D_R3, SRC_R3,  SRC_T,   32'd0);
          default: ;
        endcase
      end
      4'd5: begin
        case (pc)
          5'd0:  p = ins(OP_SHR, D_R3, SRC_T,   SRC_IMM, 32'd15);
          5'd1:  p = ins(OP_OR,  D_R3, SRC_R3,  SRC_IMM, 32'd1);
          5'd2:  p = ins(OP_ADD, D_R3, SRC_R3,  SRC_T,   32'd0);
          5'd3:  p = ins(OP_XOR, D_R3, SRC_R3,  SRC_T,   32'd0);
          5'd4:  p = ins(OP_SHR, D_R4, SRC_A,   SRC_IMM, 32'd1);
          5'd5:  p = ins(OP_SUB, D_R4, SRC_IMM, SRC_R4,  32'd1280);
          5'd6:  p = ins(OP_SUB, D_R4, SRC_T,   SRC_R4,  32'd0);
          5'd7:  p = ins(OP_XOR, D_R4, SRC_R4,  SRC_T,   32'd0);
          5'd8:  p = ins(OP_DIV5, D_R5, SRC_B,   SRC_IMM, 32'd5);
          5'd9:  p = ins(OP_SUB, D_R5, SRC_IMM, SRC_R5,  32'd10);
          5'd10: p = ins(OP_SHR, D_R4, SRC_R4,  SRC_R5,  32'd0);
          5'd11: p = ins(OP_XOR, D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd12: p = ins(OP_MUL, D_R3, SRC_R3,  SRC_T,   32'd0);
          default: ;
        endcase
      end
      4'd6: begin
        case (pc)
          5'd0: p = ins(OP_SHR, D_R3, SRC_T,  SRC_IMM, 32'd8);
          5'd1: p = ins(OP_AND, D_R3, SRC_R3, SRC_B,   32'd0);
          5'd2: p = ins(OP_SHR, D_R4, SRC_T,  SRC_IMM, 32'd4);
          5'd3: p = ins(OP_AND, D_R3, SRC_R3, SRC_R4,  32'd0);
          5'd4: p = ins(OP_MUL, D_R3, SRC_R3, SRC_T,   32'd0);
          default: ;
        endcase
      end
      4'd7: begin
        case (pc)
          5'd0:  p = ins(OP_SHR, D_R3, SRC_A,   SRC_IMM, 32'd1);
          5'd1:  p = ins(OP_ADD, D_R3, SRC_R3,  SRC_IMM, 32'd12);
          5'd2:  p = ins(OP_SHR, D_R3, SRC_T,   SRC_R3,  32'd0);
          5'd3:  p = ins(OP_AND, D_R3, SRC_R3,  SRC_T,   32'd0);
          5'd4:  p = ins(OP_SHR, D_R4, SRC_B,   SRC_IMM, 32'd1);
          5'd5:  p = ins(OP_SUB, D_R4, SRC_IMM, SRC_R4,  32'd8);
          5'd6:  p = ins(OP_SHR, D_R4, SRC_T,   SRC_R4,  32'd0);
          5'd7:  p = ins(OP_SHR, D_R5, SRC_T,   SRC_IMM, 32'd4);
          5'd8:  p = ins(OP_OR,  D_R4, SRC_R4,  SRC_R5,  32'd0);
          5'd9:  p = ins(OP_MUL, D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd10: p = ins(OP_SHR, D_R4, SRC_T,   SRC_IMM, 32'd6);
          5'd11: p = ins(OP_XOR, D_R3, SRC_R3,  SRC_R4,  32'd0);
          default: ;
        endcase
      end
      4'd8: begin
        case (pc)
          5'd0: p = ins(OP_SHR, D_R3, SRC_T,  SRC_IMM, 32'd9);
          5'd1: p = ins(OP_SHR, D_R4, SRC_A,  SRC_IMM, 32'd1);
          5'd2: p = ins(OP_ADD, D_R4, SRC_R4, SRC_IMM, 32'd1);
          5'd3: p = ins(OP_SUB, D_R4, SRC_R3, SRC_R4,  32'd0);
          5'd4: p = ins(OP_XOR, D_R3, SRC_R3, SRC_R4,  32'd0);
          5'd5: p = ins(OP_XOR, D_R3, SRC_R3, SRC_IMM, 32'd1);
          5'd6: p = ins(OP_SHR, D_R4, SRC_B,  SRC_IMM, 32'd1);
          5'd7: p = ins(OP_ADD, D_R4, SRC_R4, SRC_IMM, 32'd13);
          5'd8: p = ins(OP_MOD, D_R3, SRC_R3, SRC_R4,  32'd0);
          5'd9: p = ins(OP_MUL, D_R3, SRC_R3, SRC_T,   32'd0);
          default: ;
        endcase
      end
      4'd9: begin
        case (pc)
          5'd0:  p = ins(OP_SHR, D_R3, SRC_A,   SRC_IMM, 32'd1);
          5'd1:  p = ins(OP_ADD, D_R3, SRC_R3,  SRC_IMM, 32'd12);
          5'd2:  p = ins(OP_SHR, D_R3, SRC_T,   SRC_R3,  32'd0);
          5'd3:  p = ins(OP_SHR, D_R4, SRC_T,   SRC_IMM, 32'd8);
          5'd4:  p = ins(OP_OR,  D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd5:  p = ins(OP_SHR, D_R4, SRC_B,   SRC_IMM, 32'd1);
          5'd6:  p = ins(OP_SUB, D_R4, SRC_IMM, SRC_R4,  32'd63);
          5'd7:  p = ins(OP_AND, D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd8:  p = ins(OP_SHR, D_R4, SRC_T,   SRC_IMM, 32'd4);
          5'd9:  p = ins(OP_AND, D_R3, SRC_R3,  SRC_R4,  32'd0);
          5'd10: p = ins(OP_MUL, D_R3, SRC_R3,  SRC_T,   32'd0);
          default: ;
        endcase
      end
      default: ;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/bytebeat_sample_generator.sv -----
// Top level: tick handshake, button and time-loop state, result register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: btn_next_level, btn_prev_level, knob_a, knob_b
//  m_*      out  m_tvalid/m_tready  tdata: sample, song_index
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (16 bits)
//
// The time a tick takes is set by the song's microcode length on the shared unit,
// plus a bit-serial divider run for each divide or modulo, and the start and hand-off.
// Button, loop and time state update in the cycle the tick is accepted.
// Reset is synchronous; a finished sample waits in the output register while the
// next tick is taken, and the engine holds its result if that register is still full.
module bytebeat_sample_generator
  import bsg_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // btn_next_level, btn_prev_level, knob_a[7:0], knob_b[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // sample[7:0], song_index[3:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] click_gap_min, click_gap_max, click_timeout, hold_min;
  logic [TIME_BITS-1:0] time_count, time_count_next;
  logic [TIME_BITS-1:0] loop_start, loop_start_next;
  logic [TIME_BITS-1:0] span;
  logic [3:0]  song, song_next;
  logic        prev_level_next, prev_level_prev;
  logic        click_armed, click_armed_next;
  logic [15:0] click_ticks, click_ticks_next;
  logic        looping, looping_next;
  logic [15:0] loop_ticks, loop_ticks_next;
  logic [15:0] loop_length, loop_length_next;
  logic [15:0] hold_ticks, hold_ticks_next;

  logic        now1, now2;
  logic        accept;
  logic        busy;
  logic        res_ready;
  logic [3:0]  song_used;
  logic        eng_done;
  logic [7:0]  eng_sample;
  logic [31:0] t_ext;

  assign now1      = s_tdata[0];
  assign now2      = s_tdata[1];
  assign s_tready  = !busy;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign span      = time_count - loop_start;

  always_comb begin
    t_ext = 32'd0;
    t_ext[TIME_BITS-1:0] = time_count;
  end

  always_comb begin
    time_count_next  = time_count;
    loop_start_next  = loop_start;
    song_next        = song;
    click_armed_next = click_armed;
    click_ticks_next = click_ticks;
    looping_next     = looping;
    loop_ticks_next  = loop_ticks;
    loop_length_next = loop_length;
    hold_ticks_next  = hold_ticks;

    if (prev_level_next != now1 && !now1) begin
      looping_next    = 1'b0;
      loop_start_next = time_count;
      if (!click_armed) begin
        click_armed_next = 1'b1;
        click_ticks_next = 16'd0;
      end else if (click_ticks > click_gap_min) begin
        if (click_ticks < click_gap_max)
          song_next = (song < SONG_LAST) ? song + 4'd1 : 4'd0;
        click_armed_next = 1'b0;
        click_ticks_next = 16'd0;
      end
    end else if (prev_level_next != now1 && now1) begin
      loop_length_next = span[15:0];
      if (hold_ticks > hold_min) looping_next = 1'b1;
      hold_ticks_next = 16'd0;
    end else if (!now1) begin
      hold_ticks_next = hold_ticks + 16'd1;
    end

    if (looping_next) begin
      loop_ticks_next = loop_ticks + 16'd1;
      if (loop_ticks_next > loop_length_next) begin
        loop_ticks_next = 16'd0;
        time_count_next = loop_start_next;
      end
    end

    if (prev_level_prev != now2 && now2)
      song_next = (song_next > 4'd0) ? song_next - 4'd1 : SONG_LAST;

    time_count_next = time_count_next + {{(TIME_BITS-1){1'b0}}, 1'b1};

    if (click_armed_next) begin
      click_ticks_next = click_ticks_next + 16'd1;
      if (click_ticks_next > click_timeout) begin
        click_armed_next = 1'b0;
        click_ticks_next = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      click_gap_min   <= 16'd1000;
      click_gap_max   <= 16'd7350;
      click_timeout   <= 16'd11025;
      hold_min        <= 16'd2756;
      time_count      <= '0;
      loop_start      <= '0;
      song            <= 4'd0;
      prev_level_next <= 1'b1;
      prev_level_prev <= 1'b1;
      click_armed     <= 1'b0;
      click_ticks     <= 16'd0;
      looping         <= 1'b0;
      loop_ticks      <= 16'd0;
      loop_length     <= 16'd0;
      hold_ticks      <= 16'd0;
      busy            <= 1'b0;
      res_ready       <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index[7:2] == 6'd0) begin
        unique case (cfg_index[1:0])
          REG_GAP_MIN: click_gap_min <= cfg_data;
          REG_GAP_MAX: click_gap_max <= cfg_data;
          REG_TIMEOUT: click_timeout <= cfg_data;
          REG_HOLD:    hold_min      <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        time_count      <= time_count_next;
        loop_start      <= loop_start_next;
        song            <= song_next;
        prev_level_next <= now1;
        prev_level_prev <= now2;
        click_armed     <= click_armed_next;
        click_ticks     <= click_ticks_next;
        looping         <= looping_next;
        loop_ticks      <= loop_ticks_next;
        loop_length     <= loop_length_next;
        hold_ticks      <= hold_ticks_next;
        busy            <= 1'b1;
      end
      if (eng_done) res_ready <= 1'b1;
      // move the finished sample out once the output register is free
      if (res_ready && (!m_tvalid || m_tready)) begin
        m_tvalid  <= 1'b1;
        res_ready <= 1'b0;
        busy      <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) song_used <= song;
    if (res_ready && (!m_tvalid || m_tready))
      m_tdata <= {4'd0, song_used, eng_sample};
  end

  bsg_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .t_in    (t_ext),
    .a_in    (s_tdata[9:2]),
    .b_in    (s_tdata[17:10]),
    .song_in (song),
    .done    (eng_done),
    .sample  (eng_sample)
  );

endmodule

// ----- rtl/bsg_alu.sv -----
// Shared arithmetic unit: simple ops with a registered result and a bit-serial divider for quotient and remainder.
module bsg_alu
  import bsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  alu_req_t    req,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic        done,
  output logic [31:0] result
);

  logic        div_busy;
  logic        want_rem;
  logic [4:0]  div_count;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] divisor;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic [31:0] simple;
  logic [15:0] div5_prod;

  assign rem_sh = {rem, quo[31]};
  assign diff   = rem_sh - {1'b0, divisor};
  // divide a knob reading by five: reciprocal 205/1024 is exact over 8 bits
  assign div5_prod = {8'd0, x[7:0]} * 16'd205;

  always_comb begin
    case (req.op)
      OP_ADD:  simple = x + y;
      OP_SUB:  simple = x - y;
      OP_MUL:  simple = x * y;
      OP_AND:  simple = x & y;
      OP_OR:   simple = x | y;
      OP_XOR:  simple = x ^ y;
      // negative or oversize counts give zero
      OP_SHR:  simple = (y[31:5] != 27'd0) ? 32'd0 : (x >> y[4:0]);
      OP_DIV5: simple = {26'd0, div5_prod[15:10]};
      default: simple = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy  <= 1'b0;
      done      <= 1'b0;
      div_count <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.op == OP_DIV || req.op == OP_MOD) begin
          div_busy  <= 1'b1;
          div_count <= 5'd31;
        end else begin
          done <= 1'b1;
        end
      end else if (div_busy) begin
        if (div_count == 5'd0) begin
          div_busy <= 1'b0;
          done     <= 1'b1;
        end
        div_count <= div_count - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      result   <= simple;
      quo      <= x;
      rem      <= 32'd0;
      divisor  <= y;
      want_rem <= (req.op == OP_MOD);
    end else if (div_busy) begin
      // restoring step: one quotient bit per cycle
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
      if (div_count == 5'd0) begin
        if (want_rem) result <= !diff[32] ? diff[31:0] : rem_sh[31:0];
        else          result <= {quo[30:0], !diff[32]};
      end
    end
  end

endmodule

// ----- rtl/bsg_engine.sv -----
// Formula sequencer: steps the song's microcode through the shared unit.
module bsg_engine
  import bsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] t_in,
  input  logic [7:0]  a_in,
  input  logic [7:0]  b_in,
  input  logic [3:0]  song_in,
  output logic        done,
  output logic [7:0]  sample
);

  eng_state_t  state;
  eng_state_t  state_next;
  logic [4:0]  pc;
  logic [31:0] t_r;
  logic [7:0]  a_r;
  logic [7:0]  b_r;
  logic [3:0]  song_r;
  instr_t      cur;
  instr_t      held;
  logic [31:0] scratch [3];
  logic [31:0] opx;
  logic [31:0] opy;
  alu_req_t    req;
  logic        alu_done;
  logic [31:0] alu_result;

  assign cur = prog(song_r, pc);

  function automatic logic [31:0] pick(input logic [2:0] src, input logic [31:0] t,
                                       input logic [7:0] a, input logic [7:0] b,
                                       input logic [31:0] imm, input logic [31:0] tmp);
    logic [31:0] v;
    case (src)
      SRC_T:   v = t;
      SRC_A:   v = {24'd0, a};
      SRC_B:   v = {24'd0, b};
      SRC_IMM: v = imm;
      default: v = tmp;
    endcase
    return v;
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE:  if (start) state_next = ENG_FETCH;
      ENG_FETCH: state_next = (cur.op == OP_END) ? ENG_IDLE : ENG_EXEC;
      ENG_EXEC:  state_next = ENG_WAIT;
      ENG_WAIT:  if (alu_done) state_next = ENG_FETCH;
      default:   state_next = ENG_IDLE;
    endcase
  end

  always_comb begin
    req.start = 1'b0;
    req.op    = held.op;
    done      = 1'b0;
    unique case (state)
      ENG_FETCH: done = (cur.op == OP_END);
      ENG_EXEC:  req.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
      pc    <= 5'd0;
    end else begin
      state <= state_next;
      if (state == ENG_IDLE) pc <= 5'd0;
      else if (state == ENG_WAIT && alu_done) pc <= pc + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ENG_IDLE && start) begin
      t_r    <= t_in;
      a_r    <= a_in;
      b_r    <= b_in;
      song_r <= song_in;
      sample <= 8'd0;
    end
    if (state == ENG_FETCH) begin
      held <= cur;
      opx  <= pick(cur.sa, t_r, a_r, b_r, cur.imm, scratch[cur.sa[1:0]]);
      opy  <= pick(cur.sb, t_r, a_r, b_r, cur.imm, scratch[cur.sb[1:0]]);
    end
    if (state == ENG_WAIT && alu_done) begin
      scratch[held.dst] <= alu_result;
      if (held.dst == D_R3) sample <= alu_result[7:0];
    end
  end

  bsg_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .x      (opx),
    .y      (opy),
    .done   (alu_done),
    .result (alu_result)
  );

endmodule

// ----- test/testbench.sv -----
// Testbench for the bytebeat sample generator: predicted ticks checked against results.
`timescale 1ns / 100ps

module testbench;
  import bsg_pkg::*;

  typedef struct packed {
    logic [3:0] song;
    logic [7:0] sample;
  } beat_t;

  class beat_scoreboard;
    logic [15:0] gap_min, gap_max, timeout, hold_min;
    logic [31:0] time_count, loop_start;
    logic [3:0]  song;
    logic        lvl_next, lvl_prev, armed, looping;
    logic [15:0] click_ticks, loop_ticks, loop_length, hold_ticks;
    beat_t       pending[$];
    int          errors;

    function new();
      gap_min = 1000; gap_max = 7350; timeout = 11025; hold_min = 2756;
      time_count = 0; loop_start = 0; song = 0;
      lvl_next = 1; lvl_prev = 1; armed = 0; looping = 0;
      click_ticks = 0; loop_ticks = 0; loop_length = 0; hold_ticks = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] v);
      case (idx)
        REG_GAP_MIN: gap_min = v;
        REG_GAP_MAX: gap_max = v;
        REG_TIMEOUT: timeout = v;
        REG_HOLD:    hold_min = v;
        default: ;
      endcase
    endfunction

    // out-of-range counts shift everything out
    function logic [31:0] shr(logic [31:0] v, longint s);
      if (s < 0 || s >= 32) return 32'd0;
      return v >> s;
    endfunction

    function logic [7:0] beat(logic [31:0] t, logic [3:0] sel, logic [31:0] a, logic [31:0] b);
      logic [31:0] r;
      case (sel)
        4'd0: r = ((t * (5 + a / 5)) & (t >> 7)) | ((t * 3) & shr(t, 10 - longint'(b / 5)));
        4'd1: r = ((t | shr(t, 9 + a / 2) | (t >> 7)) * t) & (shr(t, 11 + b / 2) | (t >> 9));
        4'd2: r = (((t * 9) & (t >> 4)) | ((t * 5) & shr(t, 7 + a / 2)) |
                   ((t * 3) & (t / (32'd1024 - b / 2)))) - 32'd1;
        4'd3: r = ((t >> 6) | t | shr(t, longint'(shr(t, 16 - longint'(a / 2))))) * 10 +
                  ((t >> 11) & (7 + b / 2));
        4'd4: r = t * ((shr(t, 11 - longint'(b / 2)) & (t >> 8)) & ((32'd123 - a) & (t >> 3)));
        4'd5: r = t * (t ^ (t + ((t >> 15) | 32'd1)) ^
                  shr((t - (32'd1280 - a / 2)) ^ t, 10 - longint'(b / 5)));
        4'd6: r = t * ((t >> 8) & b & (t >> 4));
        4'd7: r = ((t & shr(t, 12 + a / 2)) * ((t >> 4) | shr(t, 8 - longint'(b / 2)))) ^ (t >> 6);
        4'd8: r = t * (((t >> 9) ^ ((t >> 9) - (32'd1 + a / 2)) ^ 32'd1) % (32'd13 + b / 2));
        4'd9: r = t * ((shr(t, 12 + a / 2) | (t >> 8)) & ((32'd63 - b / 2) & (t >> 4)));
        default: r = 0;
      endcase
      return r[7:0];
    endfunction

    function void note_tick(logic n1, logic n2, logic [7:0] ka, logic [7:0] kb);
      beat_t e;
      e.sample = beat(time_count, song, {24'd0, ka}, {24'd0, kb});
      e.song = song;
      pending.push_back(e);
      if (lvl_next != n1 && !n1) begin
        looping = 0;
        loop_start = time_count;
        if (!armed) begin
          armed = 1; click_ticks = 0;
        end else if (click_ticks > gap_min) begin
          if (click_ticks < gap_max) song = (song < SONG_LAST) ? song + 4'd1 : 4'd0;
          armed = 0; click_ticks = 0;
        end
      end else if (lvl_next != n1 && n1) begin
        loop_length = 16'(time_count - loop_start);
        if (hold_ticks > hold_min) looping = 1;
        hold_ticks = 0;
      end else if (!n1) begin
        hold_ticks++;
      end
      if (looping) begin
        loop_ticks++;
        if (loop_ticks > loop_length) begin
          loop_ticks = 0; time_count = loop_start;
        end
      end
      if (lvl_prev != n2 && n2) song = (song > 0) ? song - 4'd1 : SONG_LAST;
      time_count++;
      lvl_next = n1;
      lvl_prev = n2;
      if (armed) begin
        click_ticks++;
        if (click_ticks > timeout) begin
          armed = 0; click_ticks = 0;
        end
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected sample transfer %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.sample !== e.sample) begin
        $error("sample: expected %0d actual %0d", e.sample, got.sample);
        errors++;
      end
      if (got.song !== e.song) begin
        $error("song_index: expected %0d actual %0d", e.song, got.song);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  beat_scoreboard sb = new();
  int burst_left = 0;
  int run_next = 0, run_prev = 0;
  logic lvl_n = 1, lvl_p = 1;
  int stall_mode = 0;

  bytebeat_sample_generator DUT (.*);

  always #10 clk = ~clk;

  // receiver: the stall pattern changes at random, and in one mode it never stalls
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ($urandom_range(0, 40) == 0) ? ~m_tready : m_tready;
    endcase
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_beat(beat_t'(m_tdata[11:0]));

  task automatic send_tick(logic n1, logic n2, logic [7:0] ka, logic [7:0] kb);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, kb, ka, n2, n1};
    do @(posedge clk); while (!s_tready);
    sb.note_tick(n1, n2, ka, kb);
  endtask

  // hold valid across back-to-back writes; the caller drops it after the last one
  task automatic write_reg(logic [7:0] idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // button levels come in runs; short runs make clicks, long ones make holds
  task automatic random_ticks(int count);
    repeat (count) begin
      if (run_next == 0) begin
        lvl_n = ~lvl_n;
        run_next = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 14);
      end
      if (run_prev == 0) begin
        lvl_p = ~lvl_p;
        run_prev = $urandom_range(1, 40);
      end
      run_next--;
      run_prev--;
      send_tick(lvl_n, lvl_p, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [15:0] setting [5][4];
    setting = '{'{16'd3, 16'd12, 16'd20, 16'd5},
                '{16'd0, 16'd65535, 16'd65535, 16'd0},
                '{16'd65535, 16'd0, 16'd0, 16'd65535},
                '{16'd2, 16'd8, 16'd10, 16'd3},
                '{16'd1, 16'd30, 16'd40, 16'd12}};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // walk every song backward with knobs at both extremes
    for (int i = 0; i < 10; i++) begin
      send_tick(1'b1, 1'b0, 8'd0, 8'd0);
      send_tick(1'b1, 1'b1, 8'd255, 8'd255);
    end
    send_tick(1'b0, 1'b1, 8'd123, 8'd127);
    send_tick(1'b1, 1'b1, 8'd124, 8'd128);
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(REG_GAP_MIN, setting[ph][0]);
      write_reg(REG_GAP_MAX, setting[ph][1]);
      write_reg(REG_TIMEOUT, setting[ph][2]);
      write_reg(REG_HOLD, setting[ph][3]);
      cfg_valid <= 1'b0;
      random_ticks(320);
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
